// ----- hw/rtl/sensor_command_packet_framer_defines.svh -----
// ----------------------------------------------------------------------------
// Sensor command packet framer: assertion macros
// Shared assertion forms for the framer's internal checks.
// ----------------------------------------------------------------------------
`ifndef SENSOR_COMMAND_PACKET_FRAMER_DEFINES_SVH
`define SENSOR_COMMAND_PACKET_FRAMER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SCPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must never be seen.
`define SCPF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/scpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor command packet framer package
// Shared constants, byte positions and job types.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int MAX_PAYLOAD = 63;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] CFG_SYNC_WORD      = 2'd0;
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_PACKET_TYPE    = 2'd2;

  localparam logic [15:0] SYNC_WORD_RST      = 16'hEF01;
  localparam logic [31:0] DEVICE_ADDRESS_RST = 32'hFFFF_FFFF;
  localparam logic [7:0]  PACKET_TYPE_RST    = 8'h01;

  localparam logic [6:0] LEN_OVERHEAD = 7'd3;

  localparam logic [3:0] IDX_SC_HI   = 4'd0;
  localparam logic [3:0] IDX_SC_LO   = 4'd1;
  localparam logic [3:0] IDX_ADDR_3  = 4'd2;
  localparam logic [3:0] IDX_ADDR_2  = 4'd3;
  localparam logic [3:0] IDX_ADDR_1  = 4'd4;
  localparam logic [3:0] IDX_ADDR_0  = 4'd5;
  localparam logic [3:0] IDX_TYPE    = 4'd6;
  localparam logic [3:0] IDX_LEN_HI  = 4'd7;
  localparam logic [3:0] IDX_LEN_LO  = 4'd8;
  localparam logic [3:0] IDX_VALUE   = 4'd9;
  localparam logic [3:0] IDX_SUM_HI  = 4'd10;
  localparam logic [3:0] IDX_SUM_LO  = 4'd11;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [31:0] device_address;
    logic [7:0]  packet_type;
  } cfg_t;

  typedef struct packed {
    logic        hdr;
    logic [7:0]  value;
    logic [6:0]  len;
    logic        with_sum;
    logic [15:0] sum;
  } job_t;

  typedef struct packed {
    logic       open_packet;
    logic [5:0] bytes_left;
  } front_stat_t;

endpackage

// ----- hw/rtl/scpf_front.sv -----
// ----------------------------------------------------------------------------
// Framer front end
// Accepts input items, keeps the packet state and the running sum, and
// turns each useful item into a job for the byte emitter.
// ----------------------------------------------------------------------------
module scpf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  first,
  input  logic [5:0]            payload_count,
  input  logic [7:0]            value,
  input  logic [7:0]            packet_type,
  output logic                  push,
  output scpf_pkg::job_t        job,
  output scpf_pkg::front_stat_t stat
);
  import scpf_pkg::*;

  logic        open_r, open_nxt;
  logic [5:0]  left_r, left_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [5:0]  count_c;
  logic [6:0]  len_c;

  always_comb begin
    count_c = (payload_count > 6'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : payload_count;
    len_c   = {1'b0, count_c} + LEN_OVERHEAD;
    open_nxt = open_r;
    left_nxt = left_r;
    sum_nxt  = sum_r;
    push     = 1'b0;
    job.hdr      = first;
    job.value    = value;
    job.len      = len_c;
    job.with_sum = 1'b0;
    if (accept) begin
      if (first) begin
        sum_nxt  = 16'(packet_type) + 16'(len_c) + 16'(value);
        left_nxt = count_c;
        open_nxt = (count_c != 6'd0);
        job.with_sum = (count_c == 6'd0);
        push = 1'b1;
      end else if (open_r) begin
        sum_nxt  = sum_r + 16'(value);
        left_nxt = (left_r != 6'd0) ? left_r - 6'd1 : left_r;
        job.with_sum = (left_nxt == 6'd0);
        open_nxt = (left_nxt != 6'd0);
        push = 1'b1;
      end
    end
    job.sum = sum_nxt;
    stat.open_packet = open_r;
    stat.bytes_left  = left_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= '0;
      sum_r  <= '0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

// ----- hw/rtl/scpf_queue.sv -----
// ----------------------------------------------------------------------------
// Framer job queue
// Short first-in first-out store of jobs between front end and emitter.
// ----------------------------------------------------------------------------
module scpf_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  scpf_pkg::job_t         push_job,
  input  logic                   pop,
  output scpf_pkg::job_t         head,
  output logic                   empty,
  output logic                   full,
  output logic [scpf_pkg::QCW-1:0] count
);
  import scpf_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  always_comb begin
    do_push = push && (cnt_r != QCW'(QDEPTH));
    do_pop  = pop && (cnt_r != '0);
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    head  = mem_r[rd_r];
    empty = (cnt_r == '0);
    full  = (cnt_r == QCW'(QDEPTH));
    count = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/scpf_back.sv -----
// ----------------------------------------------------------------------------
// Framer byte emitter
// Walks each queued job byte by byte into the registered output stage.
// ----------------------------------------------------------------------------
module scpf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  scpf_pkg::cfg_t cfg,
  input  scpf_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  output logic           mid,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);
  import scpf_pkg::*;

  logic       mid_r, mid_nxt;
  logic [3:0] step_r, step_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic [3:0] idx;
  logic [3:0] end_idx;
  logic [7:0] byte_c;

  always_comb begin
    idx     = mid_r ? step_r : (head.hdr ? IDX_SC_HI : IDX_VALUE);
    end_idx = head.with_sum ? IDX_SUM_LO : IDX_VALUE;
    unique case (idx)
      IDX_SC_HI:  byte_c = cfg.sync_word[15:8];
      IDX_SC_LO:  byte_c = cfg.sync_word[7:0];
      IDX_ADDR_3: byte_c = cfg.device_address[31:24];
      IDX_ADDR_2: byte_c = cfg.device_address[23:16];
      IDX_ADDR_1: byte_c = cfg.device_address[15:8];
      IDX_ADDR_0: byte_c = cfg.device_address[7:0];
      IDX_TYPE:   byte_c = cfg.packet_type;
      IDX_LEN_HI: byte_c = 8'd0;
      IDX_LEN_LO: byte_c = {1'b0, head.len};
      IDX_VALUE:  byte_c = head.value;
      IDX_SUM_HI: byte_c = head.sum[15:8];
      IDX_SUM_LO: byte_c = head.sum[7:0];
      default:    byte_c = 8'd0;
    endcase
    load     = (!vld_r || out_tready) && !empty;
    pop      = load && (idx == end_idx);
    mid_nxt  = mid_r;
    step_nxt = step_r;
    vld_nxt  = vld_r && !out_tready;
    if (load) begin
      vld_nxt  = 1'b1;
      mid_nxt  = !pop;
      step_nxt = idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_c;
      last_r <= pop && head.with_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r  <= 1'b0;
      step_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      mid_r  <= mid_nxt;
      step_r <= step_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign mid        = mid_r;
  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

endmodule

// ----- hw/rtl/sensor_command_packet_framer.sv -----
// ----------------------------------------------------------------------------
// Sensor command packet framer
// Frames command packets for a serial sensor link, one byte per transaction.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// in_*      slave      tuser: first; tdata: payload_count, value
// out_*     master     tdata: out_byte; tlast: last
// cfg_*     slave      register index and write data
//
// An input item is taken every cycle while the job queue has room.
// An opening item yields 10 bytes (12 with an empty payload), a payload item
// 1 byte (3 on the final one); the emitter sends one byte per cycle while
// out_tready is high. Reset is synchronous; configuration is always ready.
// A stalled output holds its byte while the four-job queue fills behind it.
// ----------------------------------------------------------------------------
`include "sensor_command_packet_framer_defines.svh"

module sensor_command_packet_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] payload_count, [13:6] value, [15:14] zero
  input  logic        in_tuser,   // [0] first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import scpf_pkg::*;

  cfg_t           cfg_r;
  logic           in_acc;
  logic           push;
  job_t           push_job;
  job_t           head;
  logic           empty, full, pop, mid;
  logic [QCW-1:0] qcount;
  front_stat_t    stat;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_word      <= SYNC_WORD_RST;
      cfg_r.device_address <= DEVICE_ADDRESS_RST;
      cfg_r.packet_type    <= PACKET_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_WORD:      cfg_r.sync_word      <= cfg_data[15:0];
        CFG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_data;
        CFG_PACKET_TYPE:    cfg_r.packet_type    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  scpf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_acc),
    .first         (in_tuser),
    .payload_count (in_tdata[5:0]),
    .value         (in_tdata[13:6]),
    .packet_type   (cfg_r.packet_type),
    .push          (push),
    .job           (push_job),
    .stat          (stat)
  );

  scpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full),
    .count    (qcount)
  );

  scpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .mid        (mid),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `SCPF_ASSERT_IMPL(a_no_overflow, push, qcount != QCW'(QDEPTH), "job pushed into full queue")
  `SCPF_ASSERT_IMPL(a_open_has_left, stat.open_packet, stat.bytes_left != 6'd0,
                    "open packet with nothing left")
  `SCPF_ASSERT_IMPL(a_mid_has_job, mid, !empty, "emitter mid-job with empty queue")
  `SCPF_ASSERT_NEVER(a_count_range, qcount > QCW'(QDEPTH), "queue count beyond depth")

endmodule

// ----- tb/sv/sensor_command_packet_framer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor command packet framer testbench
// Drives opening and payload items into the framer and checks every output
// byte, in order, against a cycle-free model of the packet format. A short
// table of hand-picked items comes first: register reset values and extremes,
// stray payload, restarts and empty packets. Randomised packets follow in
// phases, each under its own register setting and stall pattern.
// ----------------------------------------------------------------------------
module sensor_command_packet_framer_test;
  import scpf_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int PHASE_ITEMS = 50;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam cfg_t REGS_ZERO = '0;
  localparam cfg_t REGS_ONES = '1;
  localparam cfg_t REGS_RESET = '{SYNC_WORD_RST, DEVICE_ADDRESS_RST, PACKET_TYPE_RST};

  typedef struct packed {
    logic [7:0] data;
    logic       ends;
  } wire_byte_t;

  typedef struct packed {
    logic        is_cfg;
    logic        spare;
    cfg_t        regs;
    logic        first;
    logic [5:0]  count;
    logic [7:0]  value;
    logic        lit;
    logic [3:0]  lit_n;
    logic [95:0] lit_bytes;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Hand-typed expectations travel alongside the item they belong to.
  logic        tag_lit = 1'b0;
  logic [3:0]  tag_lit_n = '0;
  logic [95:0] tag_lit_bytes = '0;

  cfg_t        model_regs = REGS_RESET;
  logic        fr_open = 1'b0;
  logic [5:0]  fr_left = '0;
  logic [15:0] fr_sum = '0;

  wire_byte_t  pending_bytes[$];
  int          mismatches = 0;
  int          items_taken = 0;
  int          packets_opened = 0;
  int          bytes_checked = 0;
  int          settings_used = 0;
  int          stim_items = 0;
  logic        drv_open = 1'b0;
  logic        tx_idle = 1'b1;
  logic        rx_idle = 1'b1;

  step_t directed_steps [0:22] = '{
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd0,  8'h00, 1'b1, 4'd12,
      96'hEF01_FFFF_FFFF_01_0003_00_0004},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd0,  8'hFF, 1'b1, 4'd12,
      96'hEF01_FFFF_FFFF_01_0003_FF_0103},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'h2A, 8'hAA, 1'b1, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd1,  8'h10, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'h15, 8'hFF, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'h3F, 8'h55, 1'b1, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd63, 8'h5A, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'd0,  8'h00, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd2,  8'h81, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'd0,  8'hFF, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'd0,  8'h00, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd3,  8'hC3, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'd0,  8'h7E, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd0,  8'h3C, 1'b0, 4'd0, 96'h0},
    '{1'b1, 1'b0, REGS_ZERO, 1'b0, 6'd0,  8'h00, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd0,  8'h00, 1'b1, 4'd12,
      96'h0000_0000_0000_00_0003_00_0003},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd2,  8'hFF, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'd0,  8'h80, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'd0,  8'h7F, 1'b0, 4'd0, 96'h0},
    '{1'b1, 1'b1, REGS_ONES, 1'b0, 6'd0,  8'h00, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd0,  8'hFF, 1'b1, 4'd12,
      96'hFFFF_FFFF_FFFF_FF_0003_FF_0201},
    '{1'b0, 1'b0, REGS_ZERO, 1'b1, 6'd1,  8'h01, 1'b0, 4'd0, 96'h0},
    '{1'b0, 1'b0, REGS_ZERO, 1'b0, 6'd0,  8'hFF, 1'b0, 4'd0, 96'h0}
  };

  sensor_command_packet_framer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Works out the bytes that one input item puts on the wire.
  function automatic void frame_item(input logic first, input logic [5:0] count,
                                     input logic [7:0] value, output wire_byte_t res[$]);
    logic [15:0] len;
    logic        close;
    res = {};
    close = 1'b0;
    if (first) begin
      len = 16'(count) + 16'(LEN_OVERHEAD);
      res.push_back({model_regs.sync_word[15:8], 1'b0});
      res.push_back({model_regs.sync_word[7:0], 1'b0});
      res.push_back({model_regs.device_address[31:24], 1'b0});
      res.push_back({model_regs.device_address[23:16], 1'b0});
      res.push_back({model_regs.device_address[15:8], 1'b0});
      res.push_back({model_regs.device_address[7:0], 1'b0});
      res.push_back({model_regs.packet_type, 1'b0});
      res.push_back({len[15:8], 1'b0});
      res.push_back({len[7:0], 1'b0});
      res.push_back({value, 1'b0});
      fr_sum = 16'(model_regs.packet_type) + 16'(len[15:8]) + 16'(len[7:0]) + 16'(value);
      fr_left = count;
      fr_open = 1'b1;
      close = (count == 6'd0);
    end else if (fr_open) begin
      res.push_back({value, 1'b0});
      fr_sum = fr_sum + 16'(value);
      if (fr_left != 6'd0) fr_left = fr_left - 6'd1;
      close = (fr_left == 6'd0);
    end
    if (close) begin
      res.push_back({fr_sum[15:8], 1'b0});
      res.push_back({fr_sum[7:0], 1'b1});
      fr_open = 1'b0;
      fr_left = '0;
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    wire_byte_t fresh[$];
    wire_byte_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        frame_item(in_tuser, in_tdata[5:0], in_tdata[13:6], fresh);
        if (tag_lit) begin
          for (int k = 0; k < tag_lit_n; k++)
            pending_bytes.push_back({tag_lit_bytes[95 - 8 * k -: 8], k == tag_lit_n - 1});
        end else begin
          foreach (fresh[k]) pending_bytes.push_back(fresh[k]);
        end
        items_taken++;
        if (in_tuser) packets_opened++;
      end
      if (out_tvalid && out_tready) begin
        bytes_checked++;
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("Unexpected output byte %02h last %0b at %0t",
                                    out_tdata, out_tlast, $realtime));
        end else begin
          want = pending_bytes.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.ends)
            report_mismatch($sformatf(
              "Byte mismatch at %0t: expected %02h last %0b, got %02h last %0b",
              $realtime, want.data, want.ends, out_tdata, out_tlast));
        end
      end
    end
  end

  task automatic send_item(input logic first, input logic [5:0] count, input logic [7:0] value,
                           input logic lit, input logic [3:0] lit_n, input logic [95:0] lit_bytes);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= first;
    in_tdata <= {2'b00, value, count};
    tag_lit <= lit;
    tag_lit_n <= lit_n;
    tag_lit_bytes <= lit_bytes;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t regs, input logic spare);
    logic [1:0]  idx_list[$];
    logic [31:0] val_list[$];
    logic [31:0] junk;
    junk = $urandom;
    idx_list = '{CFG_SYNC_WORD, CFG_DEVICE_ADDRESS, CFG_PACKET_TYPE};
    val_list = '{{junk[31:16], regs.sync_word}, regs.device_address,
                 {junk[23:0], regs.packet_type}};
    if (spare) begin
      idx_list.push_back(CFG_SPARE);
      val_list.push_back(junk ^ 32'hA5A5_5A5A);
    end
    foreach (idx_list[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data <= val_list[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx_list[k])
        CFG_SYNC_WORD:      model_regs.sync_word = val_list[k][15:0];
        CFG_DEVICE_ADDRESS: model_regs.device_address = val_list[k];
        CFG_PACKET_TYPE:    model_regs.packet_type = val_list[k][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed packets; now and then one is cut short and left open,
  // or a stray payload byte arrives while no packet is open.
  task automatic send_packet();
    int         pick;
    int         sent;
    logic [5:0] count;
    pick = $urandom_range(0, 19);
    if (pick == 0) count = 6'd63;
    else if (pick < 3) count = 6'($urandom_range(0, 63));
    else count = 6'($urandom_range(0, 8));
    sent = count;
    if ($urandom_range(0, 9) == 0) sent = $urandom_range(0, count);
    if (!drv_open && $urandom_range(0, 7) == 0)
      send_item(1'b0, 6'($urandom), 8'($urandom), 1'b0, 4'd0, '0);
    send_item(1'b1, count, 8'($urandom), 1'b0, 4'd0, '0);
    stim_items++;
    for (int i = 0; i < sent; i++) begin
      send_item(1'b0, 6'($urandom), 8'($urandom), 1'b0, 4'd0, '0);
      stim_items++;
    end
    drv_open = (sent < count);
  endtask

  initial begin
    int   stall;
    forever begin
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int   phase;
    int   phase_end;
    cfg_t regs;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        settle();
        load_regs(directed_steps[i].regs, directed_steps[i].spare);
      end else begin
        send_item(directed_steps[i].first, directed_steps[i].count, directed_steps[i].value,
                  directed_steps[i].lit, directed_steps[i].lit_n, directed_steps[i].lit_bytes);
      end
    end
    settle();

    for (phase = 0; stim_items < RANDOM_ITEMS; phase++) begin
      tx_idle = !phase[0];
      rx_idle = !phase[1];
      case ((phase + 2) % 4)
        0: regs = REGS_ZERO;
        1: regs = REGS_ONES;
        2: regs = REGS_RESET;
        default: begin
          regs.sync_word = 16'($urandom);
          regs.device_address = $urandom;
          regs.packet_type = 8'($urandom);
        end
      endcase
      load_regs(regs, phase % 2 == 1);
      phase_end = stim_items + PHASE_ITEMS;
      while (stim_items < phase_end && stim_items < RANDOM_ITEMS) begin
        send_packet();
        if ($urandom_range(0, 9) == 0) settle();
      end
      settle();
    end

    $display("Covered %0d input transactions (%0d opening a packet) and %0d output bytes.",
             items_taken, packets_opened, bytes_checked);
    $display("Register settings loaded: %0d; mismatching bytes: %0d.",
             settings_used, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
